### sv/tdss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task slot scheduler package
// Shared types and constants for the slot ring, the head unit and the top level.
// ----------------------------------------------------------------------------
package tdss_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 8;
  localparam int unsigned MAX_RESULTS    = 8;
  localparam int unsigned RUNS_MAX       = 255;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOREADY = 2'd3
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [2:0]  slot_number;
    logic [15:0] handle_in;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot_out;
    logic [15:0] handle_out;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  runs;
  } slot_t;

  // Control handed to the head unit for the slot currently at the head.
  typedef struct packed {
    op_e  op;
    logic del_hit;
    logic add_open;
    logic disp_open;
  } head_ctl_t;

endpackage
`default_nettype wire

### sv/tdss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot ring cell
// Holds one task slot and takes its neighbour's slot whenever the ring moves.
// ----------------------------------------------------------------------------
module tdss_cell
  import tdss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  shift_i,
  input  wire slot_t slot_i,
  output slot_t      slot_o
);

  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

### sv/tdss_head.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot head unit
// Applies the current operation to the slot leaving the head of the ring.
// ----------------------------------------------------------------------------
module tdss_head
  import tdss_pkg::*;
(
  input  wire slot_t     slot_i,
  input  wire in_t       item_i,
  input  wire head_ctl_t ctl_i,
  output slot_t          slot_o,
  output logic           hit_o
);

  always_comb begin
    slot_o = slot_i;
    hit_o  = 1'b0;
    case (ctl_i.op)
      OP_TICK: begin
        if (slot_i.valid) begin
          if (slot_i.delay == '0) begin
            if (slot_i.runs != 8'(RUNS_MAX)) begin
              slot_o.runs = slot_i.runs + 8'd1;
            end
            if (slot_i.period != '0) begin
              slot_o.delay = slot_i.period;
            end
          end else begin
            slot_o.delay = slot_i.delay - 16'd1;
          end
        end
      end
      OP_ADD: begin
        if (ctl_i.add_open && !slot_i.valid) begin
          slot_o.valid  = 1'b1;
          slot_o.handle = item_i.handle_in;
          slot_o.delay  = item_i.first_delay;
          slot_o.period = item_i.repeat_period;
          slot_o.runs   = '0;
          hit_o         = 1'b1;
        end
      end
      OP_DELETE: begin
        if (ctl_i.del_hit && slot_i.valid) begin
          slot_o = '0;
          hit_o  = 1'b1;
        end
      end
      OP_DISPATCH: begin
        if (ctl_i.disp_open && slot_i.valid && slot_i.runs != '0) begin
          hit_o       = 1'b1;
          slot_o.runs = slot_i.runs - 8'd1;
          // One-shot tasks leave the table once they have run.
          if (slot_i.period == '0) begin
            slot_o = '0;
          end
        end
      end
      default: begin
        slot_o = slot_i;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/tick_driven_task_slot_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tick-driven task slot scheduler
// Time-triggered cooperative scheduler built on a ring of task slot cells.
// ----------------------------------------------------------------------------
// Usage notes.
// Commands arrive as beats on the input channel (in_valid_i, in_stall_o,
// in_data_i): tick, add task, delete task and dispatch. Results leave as beats
// on the output channel (out_valid_o, out_stall_i, out_data_o); the last beat
// belonging to a command carries last set.
// The slots sit in a ring of TASK_SLOTS cells. Every command walks the ring
// once: each cycle in which the ring is not paused, the slot at the head
// passes through the head unit, which applies the command, and re-enters the
// ring at the tail. After TASK_SLOTS moves the ring is back in its original
// order. An unstalled command is accepted in S_IDLE, walks the ring in S_WALK
// and has its final beat loaded into the output register in S_DONE.
// A dispatch gives up to eight beats; each earlier beat is loaded into the
// output register when the next ready slot reaches the head, so the first
// beat of a dispatch can appear before the walk is over. If the output
// register is still stalled at that point the ring simply pauses.
// The next command is taken while a finished beat waits in the output
// register. Reset empties every slot and leaves both channels idle.
// ----------------------------------------------------------------------------
module tick_driven_task_slot_scheduler
  import tdss_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned SelW = (IdxW > 3) ? IdxW : 3;
  localparam int unsigned CntW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  // Ring of slot cells: cell 0 is the head, the tail takes the head unit's
  // output, every other cell takes its upper neighbour.
  slot_t ring_q [TASK_SLOTS];
  slot_t head_new;
  logic  ring_shift;
  logic  head_hit;
  head_ctl_t head_ctl;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_ring
    slot_t cell_in;
    if (i == TASK_SLOTS - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_mid
      assign cell_in = ring_q[i + 1];
    end
    tdss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_shift),
      .slot_i  (cell_in),
      .slot_o  (ring_q[i])
    );
  end

  // Control and result registers.
  state_e            state_q, state_d;
  in_t               item_q, item_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic              found_q, found_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              hold_valid_q, hold_valid_d;
  out_t              hold_q, hold_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              out_free;
  logic              need_out;
  logic [SelW-1:0]   step_w;
  logic [2:0]        slot3;
  logic              walk_end;

  assign step_w   = SelW'(step_q);
  assign slot3    = step_w[2:0];
  assign walk_end = (step_q == IdxW'(TASK_SLOTS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    head_ctl.op        = item_q.opcode;
    head_ctl.del_hit   = (SelW'(item_q.slot_number) == step_w);
    head_ctl.add_open  = !found_q;
    head_ctl.disp_open = (cnt_q < CntW'(MAX_RESULTS));
  end

  tdss_head u_head (
    .slot_i (ring_q[0]),
    .item_i (item_q),
    .ctl_i  (head_ctl),
    .slot_o (head_new),
    .hit_o  (head_hit)
  );

  // A dispatch hit while a beat is already held pushes the held beat out.
  assign need_out   = head_hit && (item_q.opcode == OP_DISPATCH) && hold_valid_q;
  assign ring_shift = (state_q == S_WALK) && (!need_out || out_free);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    step_d       = step_q;
    found_d      = found_q;
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d       = in_data_i;
          step_d       = '0;
          found_d      = 1'b0;
          cnt_d        = '0;
          hold_valid_d = 1'b1;
          hold_d       = '0;
          case (in_data_i.opcode)
            OP_TICK: begin
              hold_d.status = ST_OK;
            end
            OP_ADD: begin
              hold_d.status = ST_FULL;
            end
            OP_DELETE: begin
              hold_d.status   = ST_EMPTY;
              hold_d.slot_out = in_data_i.slot_number;
            end
            OP_DISPATCH: begin
              hold_valid_d = 1'b0;
            end
            default: begin
              hold_valid_d = 1'b0;
            end
          endcase
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (ring_shift) begin
          if (head_hit) begin
            found_d         = 1'b1;
            hold_valid_d    = 1'b1;
            hold_d.status   = ST_OK;
            hold_d.slot_out = slot3;
            hold_d.last     = 1'b0;
            if (item_q.opcode == OP_DISPATCH) begin
              hold_d.handle_out = ring_q[0].handle;
              cnt_d             = cnt_q + CntW'(1);
            end
            if (need_out) begin
              out_valid_d  = 1'b1;
              out_d        = hold_q;
              out_d.last   = 1'b0;
            end
          end
          step_d = step_q + IdxW'(1);
          if (walk_end) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (hold_valid_q) begin
            out_d = hold_q;
          end else begin
            out_d        = '0;
            out_d.status = ST_NOREADY;
          end
          out_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      step_q       <= '0;
      found_q      <= 1'b0;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      hold_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      step_q       <= step_d;
      found_q      <= found_d;
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
      hold_q       <= hold_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### bench/tick_driven_task_slot_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task slot scheduler testbench
// Drives tick, add, delete and dispatch commands into the scheduler. A
// scoreboard keeps its own copy of the slot table and works out the result
// beats of every accepted command. Each returned beat is then checked field by
// field against the oldest outstanding beat.
// ----------------------------------------------------------------------------
module tick_driven_task_slot_scheduler_test
  import tdss_pkg::*;
;

  // --------------------------------------------------------------------------
  // Scoreboard: a shadow slot table plus the queue of beats still owed by the
  // block. Every accepted command is applied to the shadow table straight away.
  // Commands are taken strictly in order, so the owed beats are in order too.
  // --------------------------------------------------------------------------
  class slot_scoreboard;
    slot_t slots[TASK_SLOTS_DEF];
    out_t  owed_beats[$];
    int    errors;

    function new();
      foreach (slots[s]) slots[s] = '0;
      errors = 0;
    endfunction

    function int outstanding();
      return owed_beats.size();
    endfunction

    function void owe_beat(status_e st, logic [2:0] slot, logic [15:0] handle);
      out_t beat;
      beat.status     = st;
      beat.slot_out   = slot;
      beat.handle_out = handle;
      beat.last       = 1'b0;
      owed_beats.push_back(beat);
    endfunction

    // Applies one accepted command to the shadow table and queues its beats.
    function void note_command(in_t cmd);
      int free_slot;
      int beats;
      free_slot = -1;
      beats     = 0;
      case (cmd.opcode)
        OP_TICK: begin
          foreach (slots[s]) begin
            if (slots[s].valid) begin
              if (slots[s].delay == 16'd0) begin
                if (slots[s].runs < 8'(RUNS_MAX)) slots[s].runs = slots[s].runs + 8'd1;
                if (slots[s].period != 16'd0) slots[s].delay = slots[s].period;
              end else begin
                slots[s].delay = slots[s].delay - 16'd1;
              end
            end
          end
          owe_beat(ST_OK, 3'd0, 16'd0);
        end
        OP_ADD: begin
          for (int s = TASK_SLOTS_DEF - 1; s >= 0; s--) begin
            if (!slots[s].valid) free_slot = s;
          end
          if (free_slot < 0) begin
            owe_beat(ST_FULL, 3'd0, 16'd0);
          end else begin
            slots[free_slot].valid  = 1'b1;
            slots[free_slot].handle = cmd.handle_in;
            slots[free_slot].delay  = cmd.first_delay;
            slots[free_slot].period = cmd.repeat_period;
            slots[free_slot].runs   = 8'd0;
            owe_beat(ST_OK, 3'(free_slot), 16'd0);
          end
        end
        OP_DELETE: begin
          if (slots[cmd.slot_number].valid) begin
            slots[cmd.slot_number] = '0;
            owe_beat(ST_OK, cmd.slot_number, 16'd0);
          end else begin
            owe_beat(ST_EMPTY, cmd.slot_number, 16'd0);
          end
        end
        default: begin
          // Dispatch: one beat per slot with a pending run, lowest slot first.
          for (int s = 0; s < TASK_SLOTS_DEF && beats < MAX_RESULTS; s++) begin
            if (slots[s].valid && slots[s].runs != 8'd0) begin
              owe_beat(ST_OK, 3'(s), slots[s].handle);
              beats++;
              slots[s].runs = slots[s].runs - 8'd1;
              if (slots[s].period == 16'd0) slots[s] = '0;
            end
          end
          if (beats == 0) owe_beat(ST_NOREADY, 3'd0, 16'd0);
        end
      endcase
      owed_beats[owed_beats.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = owed_beats.pop_front();
        compare_field("status", 16'(want.status), 16'(got.status));
        compare_field("slot_out", 16'(want.slot_out), 16'(got.slot_out));
        compare_field("handle_out", want.handle_out, got.handle_out);
        compare_field("last", 16'(want.last), 16'(got.last));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself. Every input has a known value from
  // time zero onwards.
  // --------------------------------------------------------------------------
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  slot_scoreboard board = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tick_driven_task_slot_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // The receiver decides on its stall at the falling edge, so that the value is
  // settled well before the rising edge at which a beat may be taken.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Output beats are sampled at the rising edge, before any register in the
  // block has taken its new value.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) board.check_result(out_data_o);
  end

  // --------------------------------------------------------------------------
  // Command helpers.
  // --------------------------------------------------------------------------
  function automatic in_t make_command(op_e op, logic [2:0] slot, logic [15:0] handle,
                                       logic [15:0] first_delay, logic [15:0] period);
    in_t cmd;
    cmd.opcode        = op;
    cmd.slot_number   = slot;
    cmd.handle_in     = handle;
    cmd.first_delay   = first_delay;
    cmd.repeat_period = period;
    return cmd;
  endfunction

  // Timing fields are mostly tiny, so that tasks actually fall due and the
  // table churns; now and again they take any 16-bit value.
  function automatic logic [15:0] random_ticks();
    if ($urandom_range(99) < 15) return 16'($urandom());
    return 16'($urandom_range(3));
  endfunction

  function automatic in_t random_command();
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(99);
    if (pick < 40)      op = OP_TICK;
    else if (pick < 62) op = OP_ADD;
    else if (pick < 77) op = OP_DELETE;
    else                op = OP_DISPATCH;
    return make_command(op, 3'($urandom_range(7)), 16'($urandom()), random_ticks(),
                        random_ticks());
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat was
  // taken. Valid is left high so that back-to-back beats need no extra step.
  task automatic send_command(input in_t cmd);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_command(cmd);
    @(negedge clk_i);
  endtask

  // Holds the sender back until the block owes nothing more.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  int idle_plan[4]  = '{0, 53, 0, 7};
  int stall_plan[4] = '{0, 0, 53, 7};

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, every operation, adds with extreme fields,
    // a full table, deleting a live and an empty slot, and a dispatch that
    // returns several beats at once.
    send_command(make_command(OP_DISPATCH, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_command(make_command(OP_DELETE, 3'd5, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_TICK, 3'd2, 16'h1234, 16'h0000, 16'h0000));
    send_command(make_command(OP_ADD, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_ADD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_command(make_command(OP_ADD, 3'd1, 16'hA5A5, 16'h0001, 16'h0001));
    send_command(make_command(OP_ADD, 3'd2, 16'h5A5A, 16'h0000, 16'h0002));
    send_command(make_command(OP_ADD, 3'd3, 16'h0F0F, 16'h0002, 16'h0000));
    send_command(make_command(OP_ADD, 3'd4, 16'hF0F0, 16'h0000, 16'h0001));
    send_command(make_command(OP_ADD, 3'd5, 16'h8001, 16'h0001, 16'h0000));
    send_command(make_command(OP_ADD, 3'd6, 16'h7FFE, 16'h0000, 16'h0003));
    send_command(make_command(OP_ADD, 3'd0, 16'hBEEF, 16'h0003, 16'h0000));
    send_command(make_command(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_DELETE, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_DELETE, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_command(make_command(OP_ADD, 3'd4, 16'hC3C3, 16'h0000, 16'h0000));
    send_command(make_command(OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_command(make_command(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_DISPATCH, 3'd5, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_DELETE, 3'd7, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_command(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    wait_for_results();

    // Runs piling up: empty the table, park a one-shot task that is due at
    // once, and tick it several times without a dispatch. The dispatch then
    // frees it even though runs remain. A fast periodic task sits alongside
    // it to keep its count rising too.
    idle_pct  = 7;
    stall_pct = 7;
    for (int s = 0; s < TASK_SLOTS_DEF; s++) begin
      send_command(make_command(OP_DELETE, s[2:0], 16'h0000, 16'h0000, 16'h0000));
    end
    send_command(make_command(OP_ADD, 3'd0, 16'h0001, 16'h0000, 16'h0000));
    send_command(make_command(OP_ADD, 3'd0, 16'h0002, 16'h0000, 16'h0001));
    repeat (6) send_command(make_command(OP_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    repeat (2) send_command(make_command(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    wait_for_results();

    // Random part in four phases of sender idling and receiver stalling. Between
    // phases the sender holds back until every owed beat has come home.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      repeat (30) send_command(random_command());
      wait_for_results();
    end

    // Leave room for any stray beat to show up before the verdict.
    stall_pct = 0;
    repeat (4 * TASK_SLOTS_DEF) @(negedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run could take.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
